// ===== design/dthf_pkg.sv =====
// ----------------------------------------------------------------------------
// dthf_pkg: shared types and constants for the depth-to-gray hole filler
// Widths, register indexes, scaling constants and the command word passed
// from the classifier to the pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dthf_pkg;

    localparam int FRAME_WIDTH_DEF = 640;
    localparam int MAX_RUN_DEF     = 63;

    localparam int DIST_W     = 12;
    localparam int GRAY_W     = 8;
    localparam int COL_W      = 10;
    localparam int RUN_W      = 6;
    localparam int LEN_W      = RUN_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_CROP_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_RIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_HOLES = 2'd2;

    localparam logic [COL_W-1:0] CROP_RIGHT_RESET = 10'd640;

    // nearness = floor(x * 255 / 400) = (x * 41780) >> 16, exact for x in 0..400
    localparam logic [DIST_W-1:0] NEAR_RANGE      = 12'd400;
    localparam int                NEAR_W          = 9;
    localparam int                SCALE_MUL_W     = 16;
    localparam logic [SCALE_MUL_W-1:0] SCALE_MUL  = 16'd41780;
    localparam int                SCALE_SHIFT     = 16;
    localparam int                PROD_W          = NEAR_W + SCALE_MUL_W;

    localparam logic [GRAY_W-1:0] GRAY_FULL = 8'd255;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;

    typedef struct packed {
        logic [COL_W-1:0] crop_left;
        logic [COL_W-1:0] crop_right;
        logic             fill_holes;
    } cfg_t;

    // One command: run_cnt held pixels (interpolated or full scale), then an
    // optional tail pixel. The last pixel of the command carries last.
    typedef struct packed {
        logic [RUN_W-1:0]  run_cnt;
        logic              interp;
        logic [GRAY_W-1:0] anchor;
        logic              tail;
        logic [GRAY_W-1:0] tail_val;
        logic              eof;
    } cmd_t;

endpackage

`default_nettype wire

// ===== design/dthf_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// dthf_cmd_fifo: command queue between classifier and pixel generator
// Small register FIFO; read data shows the head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module dthf_cmd_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire dthf_pkg::cmd_t wr_data,
    input  wire logic          pop,
    output dthf_pkg::cmd_t     rd_data,
    output logic               full,
    output logic               empty
);
    import dthf_pkg::*;

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W:0]   count_reg;

    logic do_push;
    logic do_pop;

    assign full    = (count_reg == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/dthf_front.sv =====
// ----------------------------------------------------------------------------
// dthf_front: sample classifier
// Maps each depth sample to nearness, tracks column and run state, and
// issues one pixel-generation command per sample that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module dthf_front #(
    parameter int FRAME_WIDTH = dthf_pkg::FRAME_WIDTH_DEF,
    parameter int MAX_RUN     = dthf_pkg::MAX_RUN_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire dthf_pkg::cfg_t              cfg,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [dthf_pkg::DIST_W-1:0] s_distance,
    input  wire logic                        s_end_of_frame,
    output dthf_pkg::cmd_t                   cmd,
    output logic                             cmd_push,
    input  wire logic                        cmd_full
);
    import dthf_pkg::*;

    logic [COL_W-1:0]  column_reg,     column_next;
    logic [RUN_W-1:0]  run_len_reg,    run_len_next;
    logic [GRAY_W-1:0] anchor_reg,     anchor_next;
    logic              in_run_reg,     in_run_next;
    logic              frame_start_reg, frame_start_next;

    logic              accept;
    logic              in_window;
    logic              near;
    logic              is_full;
    logic [NEAR_W-1:0] near_x;
    logic [PROD_W-1:0] prod;
    logic [GRAY_W-1:0] gray;
    logic [COL_W:0]    col_inc;

    assign s_ready = !cmd_full;
    assign accept  = s_valid && !cmd_full;

    assign in_window = !((column_reg < cfg.crop_left) || (column_reg > cfg.crop_right));
    assign near      = (s_distance < NEAR_RANGE);
    assign near_x    = NEAR_W'(NEAR_RANGE - s_distance);
    assign prod      = PROD_W'(near_x) * PROD_W'(SCALE_MUL);
    assign gray      = (in_window && near) ? prod[SCALE_SHIFT +: GRAY_W] : '0;
    // full scale only where the distance is zero inside the window
    assign is_full   = in_window && (s_distance == '0);
    assign col_inc   = {1'b0, column_reg} + 1'b1;

    always_comb begin
        cmd              = '0;
        cmd.tail_val     = gray;
        cmd.anchor       = anchor_reg;
        cmd.eof          = s_end_of_frame;
        anchor_next      = anchor_reg;
        in_run_next      = in_run_reg;
        run_len_next     = run_len_reg;
        frame_start_next = 1'b0;

        if (!cfg.fill_holes) begin
            // flush any held run as full scale, then the pixel
            cmd.run_cnt  = in_run_reg ? run_len_reg : '0;
            cmd.tail     = 1'b1;
            anchor_next  = gray;
            in_run_next  = 1'b0;
            run_len_next = '0;
        end else if (frame_start_reg) begin
            cmd.tail    = 1'b1;
            anchor_next = gray;
        end else if (in_run_reg) begin
            if (is_full) begin
                if (run_len_reg >= RUN_W'(MAX_RUN)) begin
                    cmd.run_cnt  = run_len_reg;
                    cmd.tail     = 1'b1;
                    cmd.tail_val = GRAY_FULL;
                    anchor_next  = GRAY_FULL;
                    in_run_next  = 1'b0;
                    run_len_next = '0;
                end else begin
                    run_len_next = run_len_reg + 1'b1;
                end
            end else begin
                cmd.run_cnt  = run_len_reg;
                cmd.interp   = 1'b1;
                cmd.tail     = 1'b1;
                anchor_next  = gray;
                in_run_next  = 1'b0;
                run_len_next = '0;
            end
        end else if (is_full) begin
            in_run_next  = 1'b1;
            run_len_next = RUN_W'(1);
        end else begin
            cmd.tail    = 1'b1;
            anchor_next = gray;
        end

        if (col_inc >= (COL_W+1)'(FRAME_WIDTH)) begin
            column_next = '0;
        end else begin
            column_next = col_inc[COL_W-1:0];
        end

        if (s_end_of_frame) begin
            // a run still open at frame end goes out unfilled
            if (in_run_next) begin
                cmd.run_cnt = run_len_next;
                cmd.interp  = 1'b0;
            end
            column_next      = '0;
            frame_start_next = 1'b1;
            in_run_next      = 1'b0;
            run_len_next     = '0;
        end
    end

    assign cmd_push = accept && ((cmd.run_cnt != '0) || cmd.tail);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg      <= '0;
            run_len_reg     <= '0;
            anchor_reg      <= GRAY_FULL;
            in_run_reg      <= 1'b0;
            frame_start_reg <= 1'b1;
        end else if (accept) begin
            column_reg      <= column_next;
            run_len_reg     <= run_len_next;
            anchor_reg      <= anchor_next;
            in_run_reg      <= in_run_next;
            frame_start_reg <= frame_start_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/dthf_back.sv =====
// ----------------------------------------------------------------------------
// dthf_back: pixel generator
// Executes commands: serial divide for the run slope, then stepped linear
// interpolation (or full scale), then the tail pixel, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dthf_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire dthf_pkg::cmd_t               cmd,
    input  wire logic                         cmd_empty,
    output logic                              cmd_pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [dthf_pkg::GRAY_W-1:0]       m_gray,
    output logic                              m_last,
    output logic                              m_frame_done
);
    import dthf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_ADJ  = 5'b00100,
        ST_RUN  = 5'b01000,
        ST_TAIL = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [RUN_W-1:0]   cnt_reg;
    logic [2:0]         div_cnt_reg;
    logic [LEN_W-1:0]   rem_reg;
    logic [GRAY_W-1:0]  quo_reg;
    logic               neg_reg;
    logic signed [GRAY_W:0] dq_reg;
    logic [LEN_W-1:0]   dr_reg;
    logic [GRAY_W-1:0]  q_reg;
    logic [LEN_W-1:0]   r_reg;

    logic               m_valid_reg;
    logic [GRAY_W-1:0]  m_gray_reg;
    logic               m_last_reg;
    logic               m_frame_done_reg;

    logic               out_free;
    logic [GRAY_W:0]    diff;
    logic [LEN_W:0]     trial;
    logic               trial_ge;
    logic [LEN_W:0]     r_sum;
    logic               r_carry;
    logic [LEN_W-1:0]   r_step;
    logic signed [GRAY_W+1:0] q_sum;
    logic [GRAY_W-1:0]  q_step;

    logic               emit;
    logic [GRAY_W-1:0]  emit_gray;
    logic               emit_last;

    assign out_free = !m_valid_reg || m_ready;
    assign cmd_pop  = (state_reg == ST_IDLE) && !cmd_empty;

    // restoring divide step
    assign trial    = {rem_reg, quo_reg[GRAY_W-1]};
    assign trial_ge = (trial >= {1'b0, len_reg});

    // interpolation step: remainder accumulates the slope fraction
    assign r_sum   = {1'b0, r_reg} + {1'b0, dr_reg};
    assign r_carry = (r_sum >= {1'b0, len_reg});
    assign r_step  = r_carry ? LEN_W'(r_sum - {1'b0, len_reg}) : r_sum[LEN_W-1:0];
    assign q_sum   = $signed({2'b00, q_reg}) + $signed({dq_reg[GRAY_W], dq_reg})
                   + $signed({{(GRAY_W+1){1'b0}}, r_carry});
    assign q_step  = q_sum[GRAY_W-1:0];

    assign diff = {1'b0, cmd.tail_val} - {1'b0, cmd.anchor};

    always_comb begin
        state_next = state_reg;
        emit       = 1'b0;
        emit_gray  = cmd_reg.tail_val;
        emit_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!cmd_empty) begin
                    if (cmd.run_cnt == '0) begin
                        state_next = ST_TAIL;
                    end else if (cmd.interp) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_DIV: begin
                if (div_cnt_reg == 3'd7) begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_gray = cmd_reg.interp ? q_step : GRAY_FULL;
                    if (cnt_reg == RUN_W'(1)) begin
                        emit_last  = !cmd_reg.tail;
                        state_next = cmd_reg.tail ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                cmd_reg     <= cmd;
                len_reg     <= {1'b0, cmd.run_cnt} + 1'b1;
                cnt_reg     <= cmd.run_cnt;
                neg_reg     <= diff[GRAY_W];
                quo_reg     <= diff[GRAY_W] ? GRAY_W'(-diff) : diff[GRAY_W-1:0];
                rem_reg     <= '0;
                div_cnt_reg <= '0;
                q_reg       <= cmd.anchor;
                r_reg       <= '0;
            end
            ST_DIV: begin
                rem_reg     <= trial_ge ? LEN_W'(trial - {1'b0, len_reg}) : trial[LEN_W-1:0];
                quo_reg     <= {quo_reg[GRAY_W-2:0], trial_ge};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            ST_ADJ: begin
                // floor division of a negative slope
                if (neg_reg && (rem_reg != '0)) begin
                    dq_reg <= -$signed({1'b0, quo_reg}) - 9'sd1;
                    dr_reg <= len_reg - rem_reg;
                end else if (neg_reg) begin
                    dq_reg <= -$signed({1'b0, quo_reg});
                    dr_reg <= '0;
                end else begin
                    dq_reg <= $signed({1'b0, quo_reg});
                    dr_reg <= rem_reg;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    q_reg   <= q_step;
                    r_reg   <= r_step;
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            ST_TAIL: begin
                cnt_reg <= cnt_reg;
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_gray_reg       <= emit_gray;
            m_last_reg       <= emit_last;
            m_frame_done_reg <= emit_last && cmd_reg.eof;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_gray       = m_gray_reg;
    assign m_last       = m_last_reg;
    assign m_frame_done = m_frame_done_reg;

endmodule

`default_nettype wire

// ===== design/depth_to_gray_hole_fill.sv =====
// ----------------------------------------------------------------------------
// depth_to_gray_hole_fill: depth samples to 8-bit nearness with hole filling
// Converts raster depth to nearness, crops columns and interpolates across
// runs of full-scale pixels between two valid neighbors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): one word per depth sample, with
//   s_end_of_frame on the last sample of a frame.
//   Output channel (m_valid/m_ready): one word per gray pixel; m_last marks
//   the final pixel caused by an input sample, m_frame_done the final pixel
//   of a frame. A sample that opens or extends a held run gives no word yet.
//   Config port: write crop_left_col, crop_right_col and fill_holes through
//   cfg_wr_en/cfg_wr_index/cfg_wr_data, only while the block is idle.
// Timing:
//   A plain pixel passes the command queue, the pop and tail states and
//   the output register; the pop and tail states per plain sample set
//   sustained throughput. A filled run of n held pixels takes a pop state,
//   a serial divide for the slope, an adjust state, then one pixel a cycle
//   for the run and its ending pixel while the receiver is ready.
//   A 4-word command queue lets the classifier keep accepting meanwhile.
// Reset: clears crop window to full width, fill off, column 0, no run.
// Stall: a stalled receiver holds the output register; the queue fills and
//   s_ready drops once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_to_gray_hole_fill #(
    parameter int FRAME_WIDTH = dthf_pkg::FRAME_WIDTH_DEF,
    parameter int MAX_RUN     = dthf_pkg::MAX_RUN_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dthf_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [dthf_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [dthf_pkg::DIST_W-1:0]     s_distance,
    input  wire logic                            s_end_of_frame,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [dthf_pkg::GRAY_W-1:0]          m_gray,
    output logic                                 m_last,
    output logic                                 m_frame_done
);
    import dthf_pkg::*;

    cfg_t cfg_reg;
    cmd_t push_cmd;
    cmd_t head_cmd;
    logic cmd_push;
    logic cmd_pop;
    logic cmd_full;
    logic cmd_empty;

    // Config registers; writes to an unused index are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crop_left  <= '0;
            cfg_reg.crop_right <= CROP_RIGHT_RESET;
            cfg_reg.fill_holes <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_CROP_LEFT:  cfg_reg.crop_left  <= cfg_wr_data[COL_W-1:0];
                CFG_CROP_RIGHT: cfg_reg.crop_right <= cfg_wr_data[COL_W-1:0];
                CFG_FILL_HOLES: cfg_reg.fill_holes <= cfg_wr_data[0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Classify samples and issue commands.
    dthf_front #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .MAX_RUN     (MAX_RUN)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_distance     (s_distance),
        .s_end_of_frame (s_end_of_frame),
        .cmd            (push_cmd),
        .cmd_push       (cmd_push),
        .cmd_full       (cmd_full)
    );

    // Decouple classifier from pixel generation.
    dthf_cmd_fifo u_cmd_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (cmd_push),
        .wr_data (push_cmd),
        .pop     (cmd_pop),
        .rd_data (head_cmd),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    // Generate output pixels.
    dthf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (head_cmd),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gray       (m_gray),
        .m_last       (m_last),
        .m_frame_done (m_frame_done)
    );

endmodule

`default_nettype wire
